// File: hw/rtl/dqbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dqbf_pkg;

    // Operation codes carried by one transaction.
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SUB_FRONT  = 3'd4;
    localparam logic [2:0] OP_FIT_QUERY  = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_POPF,
        S_POPB,
        S_FIT,
        S_FIT_END,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/deque_with_budget_fit_query_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// A push goes from idle straight to the result state S_RESP; a pop passes through S_POPF or S_POPB
// and a subtract through S_SUB first; a fit query walks the entries in S_FIT, one read a cycle
// through the shared adder, then S_FIT_END. A new transaction is taken only while busy is low.
// Each result is shown for exactly one cycle with o_strobe; the receiver cannot stall it.
// Reset (synchronous, active low) empties the queue: head, occupancy and total go to zero.
// The entry memory is not cleared; only data read from occupied slots is ever used.
module deque_with_budget_fit_query_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_opcode,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [31:0] i_budget,
    output logic                    o_strobe,
    output logic [1:0]              o_status,
    output logic [6:0]              o_entry_count,
    output logic signed [31:0]      o_total,
    output logic signed [31:0]      o_front_value,
    output logic [6:0]              o_fit_count,
    output logic signed [31:0]      o_leftover
);

    // Slot index width and a width that can hold the occupancy up to DEPTH itself.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DepthX   = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);

    // Ring addition of two slot offsets; both operands stay below DEPTH.
    function automatic logic [AW-1:0] f_wrap_add(input logic [AW-1:0] a,
                                                 input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DepthX) begin
            s = s - DepthX;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_next_slot(input logic [AW-1:0] a);
        return (a == LastSlot) ? '0 : a + 1'b1;
    endfunction

    // Sequencer and queue state.
    dqbf_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_occ, n_occ;
    logic [31:0]      r_total, n_total;

    // The front entry is mirrored in a register so that every result can report it at once.
    logic [31:0]      r_front, n_front;

    // Operands of the transaction in progress.
    logic [31:0]      r_val, n_val;
    logic [31:0]      r_bud, n_bud;

    // Fit query walk: slot pointer, entries issued to memory, read outstanding, prefix sum.
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_issued, n_issued;
    logic             r_pend, n_pend;
    logic [31:0]      r_acc, n_acc;

    // Result payload.
    logic [1:0]       r_status, n_status;
    logic [CW-1:0]    r_fit, n_fit;
    logic [31:0]      r_left, n_left;

    // Entry memory: one write and one registered read a cycle.
    logic [31:0]      r_mem [DEPTH];
    logic [31:0]      r_rd_data;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [31:0]      mem_wdata;

    // The shared value adder: add_a + add_b, or add_a - add_b when add_sub is set.
    logic [31:0]      add_a, add_b, add_sum;
    logic             add_sub;

    assign add_sum = add_a + (add_b ^ {32{add_sub}}) + {31'd0, add_sub};

    // Derived slot positions.
    logic [AW-1:0]    tail_slot;
    logic [AW-1:0]    back_slot;
    logic [AW-1:0]    prev_head;
    logic [CW-1:0]    occ_less1;
    logic             fit_stop;
    logic             fit_issue;

    assign occ_less1 = r_occ - 1'b1;
    assign tail_slot = f_wrap_add(r_head, r_occ[AW-1:0]);
    assign back_slot = f_wrap_add(r_head, occ_less1[AW-1:0]);
    assign prev_head = (r_head == '0) ? LastSlot : r_head - 1'b1;

    // A returned entry stops the walk when the candidate prefix sum exceeds the budget.
    assign fit_stop  = r_pend && ($signed(add_sum) > $signed(r_bud));
    assign fit_issue = (r_issued < r_occ) && !fit_stop;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqbf_pkg::S_IDLE;
            r_head  <= '0;
            r_occ   <= '0;
            r_total <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_occ   <= n_occ;
            r_total <= n_total;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_val    <= n_val;
        r_bud    <= n_bud;
        r_ptr    <= n_ptr;
        r_issued <= n_issued;
        r_acc    <= n_acc;
        r_status <= n_status;
        r_fit    <= n_fit;
        r_left   <= n_left;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_occ     = r_occ;
        n_total   = r_total;
        n_front   = r_front;
        n_val     = r_val;
        n_bud     = r_bud;
        n_ptr     = r_ptr;
        n_issued  = r_issued;
        n_pend    = 1'b0;
        n_acc     = r_acc;
        n_status  = r_status;
        n_fit     = r_fit;
        n_left    = r_left;
        add_a     = r_total;
        add_b     = i_value;
        add_sub   = 1'b0;
        mem_raddr = r_ptr;
        mem_we    = 1'b0;
        mem_waddr = r_head;
        mem_wdata = i_value;

        unique case (r_state)
            dqbf_pkg::S_IDLE: begin
                if (start) begin
                    n_val    = i_value;
                    n_bud    = i_budget;
                    n_status = dqbf_pkg::ST_OK;
                    n_fit    = '0;
                    n_left   = '0;
                    n_state  = dqbf_pkg::S_RESP;
                    unique case (i_opcode) inside
                        dqbf_pkg::OP_PUSH_FRONT, dqbf_pkg::OP_PUSH_BACK: begin
                            if (r_occ == FullCnt) begin
                                n_status = dqbf_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_occ   = r_occ + 1'b1;
                                n_total = add_sum;
                                if (i_opcode == dqbf_pkg::OP_PUSH_FRONT) begin
                                    mem_waddr = prev_head;
                                    n_head    = prev_head;
                                    n_front   = i_value;
                                end else begin
                                    mem_waddr = tail_slot;
                                    if (r_occ == '0) begin
                                        n_front = i_value;
                                    end
                                end
                            end
                        end
                        dqbf_pkg::OP_POP_FRONT: begin
                            if (r_occ == '0) begin
                                n_status = dqbf_pkg::ST_EMPTY;
                            end else begin
                                // Fetch the entry that becomes the new front.
                                add_b     = r_front;
                                add_sub   = 1'b1;
                                n_total   = add_sum;
                                n_head    = f_next_slot(r_head);
                                mem_raddr = f_next_slot(r_head);
                                n_occ     = occ_less1;
                                n_state   = dqbf_pkg::S_POPF;
                            end
                        end
                        dqbf_pkg::OP_POP_BACK: begin
                            if (r_occ == '0) begin
                                n_status = dqbf_pkg::ST_EMPTY;
                            end else begin
                                mem_raddr = back_slot;
                                n_occ     = occ_less1;
                                n_state   = dqbf_pkg::S_POPB;
                            end
                        end
                        dqbf_pkg::OP_SUB_FRONT: begin
                            if (r_occ == '0) begin
                                n_status = dqbf_pkg::ST_EMPTY;
                            end else begin
                                add_sub = 1'b1;
                                n_total = add_sum;
                                n_state = dqbf_pkg::S_SUB;
                            end
                        end
                        dqbf_pkg::OP_FIT_QUERY: begin
                            n_ptr    = r_head;
                            n_issued = '0;
                            n_acc    = '0;
                            n_state  = dqbf_pkg::S_FIT;
                        end
                        default: begin
                            // Unused codes leave the queue as it is.
                        end
                    endcase
                end
            end
            dqbf_pkg::S_SUB: begin
                add_a     = r_front;
                add_b     = r_val;
                add_sub   = 1'b1;
                n_front   = add_sum;
                mem_we    = 1'b1;
                mem_waddr = r_head;
                mem_wdata = add_sum;
                n_state   = dqbf_pkg::S_RESP;
            end
            dqbf_pkg::S_POPF: begin
                n_front = r_rd_data;
                n_state = dqbf_pkg::S_RESP;
            end
            dqbf_pkg::S_POPB: begin
                add_b   = r_rd_data;
                add_sub = 1'b1;
                n_total = add_sum;
                n_state = dqbf_pkg::S_RESP;
            end
            dqbf_pkg::S_FIT: begin
                // One read is issued while the previous entry is summed and compared.
                add_a     = r_acc;
                add_b     = r_rd_data;
                mem_raddr = r_ptr;
                if (r_pend && !fit_stop) begin
                    n_acc = add_sum;
                    n_fit = r_fit + 1'b1;
                end
                if (fit_issue) begin
                    n_pend   = 1'b1;
                    n_ptr    = f_next_slot(r_ptr);
                    n_issued = r_issued + 1'b1;
                end else begin
                    n_state = dqbf_pkg::S_FIT_END;
                end
            end
            dqbf_pkg::S_FIT_END: begin
                add_a   = r_bud;
                add_b   = r_acc;
                add_sub = 1'b1;
                n_left  = add_sum;
                n_state = dqbf_pkg::S_RESP;
            end
            dqbf_pkg::S_RESP: begin
                n_state = dqbf_pkg::S_IDLE;
            end
            default: begin
                n_state = dqbf_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != dqbf_pkg::S_IDLE);
    assign o_strobe      = (r_state == dqbf_pkg::S_RESP);
    assign o_status      = r_status;
    assign o_entry_count = 7'(r_occ);
    assign o_total       = r_total;
    assign o_front_value = (r_occ != '0) ? r_front : 32'd0;
    assign o_fit_count   = 7'(r_fit);
    assign o_leftover    = r_left;

`ifndef SYNTHESIS
    // A result is shown for one cycle only, and the sequencer is back at rest after it.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe && !busy)
        else $error("result strobe held for more than one cycle");

    // An accepted transaction always occupies the sequencer in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the block busy");

    // The occupancy never exceeds the ring capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FullCnt)
        else $error("occupancy beyond capacity");

    // The fit walk never counts more entries than it has read from memory.
    a_fit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqbf_pkg::S_FIT) |-> (r_issued <= r_occ) && (r_fit <= r_issued))
        else $error("fit walk ran past the queue");
`endif

endmodule

`default_nettype wire
